// File: rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative cache tag controller.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int FIELD_AW  = 48;
  localparam int SET_IDX_W = 16;
  localparam int CNT_W     = 48;

  localparam logic [1:0] CFG_LINE_SHIFT    = 2'd0;
  localparam logic [1:0] CFG_SET_MASK      = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE   = 2'd2;
  localparam logic [1:0] CFG_POLICY_SELECT = 2'd3;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_NMRU = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_STORE,
    CMD_WRITEBACK
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [FIELD_AW-1:0]   addr;
    logic [FIELD_AW-1:0]   tag;
    logic [SET_IDX_W-1:0]  set_idx;
    logic                  line_clean;
  } req_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_EXEC
  } bk_state_t;

endpackage

// File: rtl/salc_front.sv
// ----------------------------------------------------------------------------
// salc_front
// Accepts accesses, normalizes the command, forms tag and set index.
// ----------------------------------------------------------------------------
module salc_front import salc_pkg::*; #(
  parameter int SETS = 8192,
  parameter int AW   = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [FIELD_AW-1:0]  in_address,
  input  logic                 in_line_clean,
  input  logic [4:0]           line_shift,
  input  logic [12:0]          set_mask,
  input  logic                 clearing,
  input  logic                 q_full,
  output logic                 q_push,
  output req_t                 q_data
);

  localparam longint unsigned RECIP = ((64'd1 << 30) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [FIELD_AW-1:0] AMASK = {FIELD_AW{1'b1}} >> (FIELD_AW - AW);

  logic                s1_v_r, s1_v_nxt;
  cmd_t                s1_cmd_r;
  logic [FIELD_AW-1:0] s1_addr_r, s1_tag_r;
  logic [12:0]         s1_sv_r;
  logic                s1_clean_r;

  logic                s2_v_r, s2_v_nxt;
  cmd_t                s2_cmd_r;
  logic [FIELD_AW-1:0] s2_addr_r, s2_tag_r;
  logic [12:0]         s2_sv_r;
  logic [13:0]         s2_q_r;
  logic                s2_clean_r;

  logic                s1_adv, s2_adv, accept;
  logic [FIELD_AW-1:0] addr_m, tag_c;
  cmd_t                cmd_c;
  logic [43:0]         prod;
  logic [30:0]         qs;
  logic [12:0]         rem;

  assign q_push   = s2_v_r && !q_full;
  assign s2_adv   = !s2_v_r || q_push;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv || clearing;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    addr_m = in_address & AMASK;
    tag_c  = addr_m >> line_shift;
    if (in_command == 2'(CMD_STORE)) begin
      cmd_c = CMD_STORE;
    end else if (in_command == 2'(CMD_WRITEBACK)) begin
      cmd_c = CMD_WRITEBACK;
    end else begin
      cmd_c = CMD_LOAD;
    end
    prod = 44'(s1_sv_r) * 44'(RECIP);
    qs   = 31'(s2_q_r) * 31'(SETS);
    rem  = s2_sv_r - qs[12:0];
    s1_v_nxt = s1_adv ? accept : s1_v_r;
    s2_v_nxt = s2_adv ? s1_v_r : s2_v_r;
  end

  always_comb begin
    q_data.cmd        = s2_cmd_r;
    q_data.addr       = s2_addr_r;
    q_data.tag        = s2_tag_r;
    q_data.set_idx    = SET_IDX_W'(rem);
    q_data.line_clean = s2_clean_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r   <= cmd_c;
      s1_addr_r  <= addr_m;
      s1_tag_r   <= tag_c;
      s1_sv_r    <= tag_c[12:0] & set_mask;
      s1_clean_r <= in_line_clean;
    end
    if (s2_adv && s1_v_r) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_addr_r  <= s1_addr_r;
      s2_tag_r   <= s1_tag_r;
      s2_sv_r    <= s1_sv_r;
      s2_q_r     <= prod[43:30];
      s2_clean_r <= s1_clean_r;
    end
  end

endmodule

// File: rtl/salc_queue.sv
// ----------------------------------------------------------------------------
// salc_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module salc_queue import salc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t wr_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output req_t rd_data
);

  req_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// File: rtl/salc_back.sv
// ----------------------------------------------------------------------------
// salc_back
// Set memory, lookup, LRU/NMRU replacement, clean flags and counters.
// ----------------------------------------------------------------------------
module salc_back import salc_pkg::*; #(
  parameter int SETS = 8192,
  parameter int WAYS = 16,
  parameter int AW   = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [4:0]          ways_in_use,
  input  logic                policy_select,
  output logic                clearing,
  input  logic                q_empty,
  input  req_t                q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [3:0]          out_way,
  output logic                out_victim_valid,
  output logic [FIELD_AW-1:0] out_victim_address,
  output logic                out_victim_clean,
  output logic                out_fill_request,
  output logic [CNT_W-1:0]    out_hit_total,
  output logic [CNT_W-1:0]    out_miss_total
);

  localparam int SIW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0][AW-1:0]     tag_mem   [SETS];
  logic [WAYS-1:0][AW-1:0]     addr_mem  [SETS];
  logic [WAYS-1:0][RANK_W-1:0] rank_mem  [SETS];
  logic [WAYS-1:0]             clean_mem [SETS];

  logic [WAYS-1:0][AW-1:0]     rd_tag_r, rd_addr_r, wr_tag, wr_addr;
  logic [WAYS-1:0][RANK_W-1:0] rd_rank_r, wr_rank, init_rank;
  logic [WAYS-1:0]             rd_clean_r, wr_clean;

  bk_state_t       state_r, state_nxt;
  logic [SIW-1:0]  clr_cnt_r, wr_set;
  req_t            cur_r;
  logic            rd_en, wr_en, out_load, out_free;

  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r;
  logic             out_valid_r;

  logic [5:0]        n6;
  logic              hit;
  logic [RANK_W-1:0] w, hit_w, vic_w, cur_rank;
  logic              vic_found;

  assign clearing  = state_r == BK_CLEAR;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        wr_en = 1'b1;
        if (clr_cnt_r == SIW'(SETS - 1)) state_nxt = BK_FETCH;
      end
      BK_FETCH: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          wr_en     = 1'b1;
          out_load  = 1'b1;
          state_nxt = BK_FETCH;
        end
      end
      default: state_nxt = BK_CLEAR;
    endcase
  end

  always_comb begin
    if (ways_in_use == 5'd0) begin
      n6 = 6'd1;
    end else if (6'(ways_in_use) > 6'(WAYS)) begin
      n6 = 6'(WAYS);
    end else begin
      n6 = 6'(ways_in_use);
    end

    hit   = 1'b0;
    hit_w = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (6'(i) < n6 && rd_tag_r[i] == cur_r.tag[AW-1:0]) begin
        hit   = 1'b1;
        hit_w = RANK_W'(i);
      end
    end

    vic_found = 1'b0;
    vic_w     = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (6'(i) < n6) begin
        if ((policy_select == POLICY_LRU && 6'(rd_rank_r[i]) == n6 - 6'd1) ||
            (policy_select == POLICY_NMRU && rd_rank_r[i] != '0)) begin
          vic_found = 1'b1;
          vic_w     = RANK_W'(i);
        end
      end
    end
    if (!vic_found) vic_w = '0;

    w        = hit ? hit_w : vic_w;
    cur_rank = rd_rank_r[w];

    for (int i = 0; i < WAYS; i++) begin
      init_rank[i] = RANK_W'(i);
      wr_tag[i]    = rd_tag_r[i];
      wr_addr[i]   = rd_addr_r[i];
      wr_clean[i]  = rd_clean_r[i];
      wr_rank[i]   = rd_rank_r[i];
      if (6'(i) < n6 && rd_rank_r[i] < cur_rank) wr_rank[i] = rd_rank_r[i] + 1'b1;
    end
    wr_rank[w] = '0;
    if (hit) begin
      if (cur_r.cmd == CMD_STORE || (cur_r.cmd == CMD_WRITEBACK && !cur_r.line_clean))
        wr_clean[w] = 1'b0;
    end else begin
      wr_tag[w]  = cur_r.tag[AW-1:0];
      wr_addr[w] = cur_r.addr[AW-1:0];
      case (cur_r.cmd)
        CMD_STORE:     wr_clean[w] = 1'b0;
        CMD_WRITEBACK: wr_clean[w] = cur_r.line_clean;
        default:       wr_clean[w] = 1'b1;
      endcase
    end

    wr_set = clearing ? clr_cnt_r : cur_r.set_idx[SIW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (clearing) begin
        tag_mem[wr_set]   <= '0;
        addr_mem[wr_set]  <= '0;
        rank_mem[wr_set]  <= init_rank;
        clean_mem[wr_set] <= '0;
      end else begin
        tag_mem[wr_set]   <= wr_tag;
        addr_mem[wr_set]  <= wr_addr;
        rank_mem[wr_set]  <= wr_rank;
        clean_mem[wr_set] <= wr_clean;
      end
    end
    if (rd_en) begin
      rd_tag_r   <= tag_mem[q_data.set_idx[SIW-1:0]];
      rd_addr_r  <= addr_mem[q_data.set_idx[SIW-1:0]];
      rd_rank_r  <= rank_mem[q_data.set_idx[SIW-1:0]];
      rd_clean_r <= clean_mem[q_data.set_idx[SIW-1:0]];
      cur_r      <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (hit) hit_cnt_r <= hit_cnt_r + 1'b1;
        else     miss_cnt_r <= miss_cnt_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit            <= hit;
      out_way            <= 4'(w);
      out_victim_valid   <= !hit;
      out_victim_address <= hit ? '0 : FIELD_AW'(rd_addr_r[w]);
      out_victim_clean   <= hit ? 1'b0 : rd_clean_r[w];
      out_fill_request   <= !hit && cur_r.cmd != CMD_WRITEBACK;
      out_hit_total      <= hit ? hit_cnt_r + 1'b1 : hit_cnt_r;
      out_miss_total     <= hit ? miss_cnt_r : miss_cnt_r + 1'b1;
    end
  end

endmodule

// File: rtl/set_assoc_cache_lru_tag_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tag_controller
// Tag, LRU/NMRU replacement and clean-flag controller of one cache level.
// ----------------------------------------------------------------------------
// Each access yields one result. The back end reads the whole set row from
// the set memory in its fetch state; its exec state compares tags, updates
// ranks and flags, writes the row back and loads the output register. The
// front end registers the tag shift (s1) and the set index reduction (s2) and
// overlaps with the back end. After reset a clearing pass over all SETS rows
// (8192 by default) initializes the set memory; no access is taken until it
// completes. Configuration writes are taken at any time.
module set_assoc_cache_lru_tag_controller import salc_pkg::*; #(
  parameter int SETS      = 8192,
  parameter int WAYS      = 16,
  parameter int ADDR_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [FIELD_AW-1:0] in_address,
  input  logic                in_line_clean,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [3:0]          out_way,
  output logic                out_victim_valid,
  output logic [FIELD_AW-1:0] out_victim_address,
  output logic                out_victim_clean,
  output logic                out_fill_request,
  output logic [CNT_W-1:0]    out_hit_total,
  output logic [CNT_W-1:0]    out_miss_total
);

  localparam int AW = (ADDR_BITS < FIELD_AW) ? ADDR_BITS : FIELD_AW;

  logic [4:0]  line_shift_r;
  logic [12:0] set_mask_r;
  logic [4:0]  ways_in_use_r;
  logic        policy_select_r;

  logic clearing, q_full, q_push, q_empty, q_pop;
  req_t q_wr_data, q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_shift_r    <= 5'd6;
      set_mask_r      <= 13'd127;
      ways_in_use_r   <= 5'd4;
      policy_select_r <= POLICY_LRU;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LINE_SHIFT:    line_shift_r    <= cfg_wdata[4:0];
        CFG_SET_MASK:      set_mask_r      <= cfg_wdata;
        CFG_WAYS_IN_USE:   ways_in_use_r   <= cfg_wdata[4:0];
        CFG_POLICY_SELECT: policy_select_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  salc_front #(.SETS(SETS), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_address(in_address), .in_line_clean(in_line_clean),
    .line_shift(line_shift_r), .set_mask(set_mask_r), .clearing(clearing),
    .q_full(q_full), .q_push(q_push), .q_data(q_wr_data)
  );

  salc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wr_data(q_wr_data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rd_data(q_rd_data)
  );

  salc_back #(.SETS(SETS), .WAYS(WAYS), .AW(AW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .ways_in_use(ways_in_use_r), .policy_select(policy_select_r),
    .clearing(clearing), .q_empty(q_empty), .q_data(q_rd_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_way(out_way), .out_victim_valid(out_victim_valid),
    .out_victim_address(out_victim_address), .out_victim_clean(out_victim_clean),
    .out_fill_request(out_fill_request), .out_hit_total(out_hit_total),
    .out_miss_total(out_miss_total)
  );

endmodule

// File: rtl/salc_checker.sv
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the cache tag controller, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker import salc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_hit,
  input logic                out_victim_valid,
  input logic [FIELD_AW-1:0] out_victim_address,
  input logic                out_victim_clean,
  input logic                out_fill_request
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
    $stable(out_victim_address))
    else $error("stalled result changed");

  a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit != out_victim_valid)
    else $error("hit and victim request disagree");

  a_fill_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_request |-> out_victim_valid)
    else $error("fill without miss");

  a_hit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_victim_address == '0 && !out_victim_clean)
    else $error("victim fields set on hit");

endmodule

bind set_assoc_cache_lru_tag_controller salc_checker u_salc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_hit(out_hit), .out_victim_valid(out_victim_valid),
  .out_victim_address(out_victim_address), .out_victim_clean(out_victim_clean),
  .out_fill_request(out_fill_request)
);

// File: test/tb_set_assoc_cache_lru_tag_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_tag_controller
// Self-checking bench for the cache tag, replacement and clean-flag controller.
// A behavioral copy of the tag, rank and flag arrays predicts every access
// result; results are compared in order. Directed cases, configuration
// extremes, back-pressure and random traffic with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_tag_controller;
  import salc_pkg::*;

  localparam int         N_SETS     = 8192;
  localparam int         N_WAYS     = 16;
  localparam int         IDLE_LIMIT = 40000;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  typedef struct {
    logic                hit;
    logic [3:0]          way;
    logic                victim_valid;
    logic [FIELD_AW-1:0] victim_address;
    logic                victim_clean;
    logic                fill_request;
    logic [CNT_W-1:0]    hit_total;
    logic [CNT_W-1:0]    miss_total;
  } access_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [12:0]         cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_command = '0;
  logic [FIELD_AW-1:0] in_address = '0;
  logic                in_line_clean = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [3:0]          out_way;
  logic                out_victim_valid;
  logic [FIELD_AW-1:0] out_victim_address;
  logic                out_victim_clean;
  logic                out_fill_request;
  logic [CNT_W-1:0]    out_hit_total;
  logic [CNT_W-1:0]    out_miss_total;

  set_assoc_cache_lru_tag_controller dut (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // model of the cache state
  logic [FIELD_AW-1:0] tag_mem   [N_SETS][N_WAYS];
  logic [FIELD_AW-1:0] laddr_mem [N_SETS][N_WAYS];
  logic [3:0]          rank_mem  [N_SETS][N_WAYS];
  logic                clean_mem [N_SETS][N_WAYS];
  logic [CNT_W-1:0]    hit_cnt, miss_cnt;
  logic [4:0]          m_line_shift;
  logic [12:0]         m_set_mask;
  logic [4:0]          m_ways;
  logic                m_policy;

  access_result_t expected_q[$];
  int unsigned    mismatches;
  int unsigned    max_gap;
  int unsigned    hold_cycles;

  function automatic void touch_way(int s, int w, int n);
    logic [3:0] cur;
    cur = rank_mem[s][w];
    for (int i = 0; i < n; i++)
      if (rank_mem[s][i] < cur) rank_mem[s][i] = rank_mem[s][i] + 4'd1;
    rank_mem[s][w] = 4'd0;
  endfunction

  function automatic access_result_t predict_access(logic [1:0] cmd,
                                                    logic [FIELD_AW-1:0] addr,
                                                    logic lclean);
    access_result_t r;
    logic [FIELD_AW-1:0] tag;
    int n, s, w;
    bit found;
    r = '{default: '0};
    if (cmd == CMD_SPARE) cmd = CMD_LOAD;
    n = m_ways;
    if (n < 1) n = 1;
    if (n > N_WAYS) n = N_WAYS;
    tag = addr >> m_line_shift;
    s = int'(tag & FIELD_AW'(m_set_mask)) % N_SETS;
    w = 0;
    found = 0;
    for (int i = 0; i < n && !found; i++)
      if (tag_mem[s][i] == tag) begin
        w = i;
        found = 1;
      end
    if (found) begin
      touch_way(s, w, n);
      if (cmd == CMD_STORE || (cmd == CMD_WRITEBACK && !lclean)) clean_mem[s][w] = 1'b0;
      hit_cnt = hit_cnt + 1'b1;
    end else begin
      found = 0;
      for (int i = 0; i < n && !found; i++)
        if ((m_policy == POLICY_LRU && int'(rank_mem[s][i]) == n - 1) ||
            (m_policy == POLICY_NMRU && rank_mem[s][i] != 0)) begin
          w = i;
          found = 1;
        end
      if (!found) w = 0;
      tag_mem[s][w] = tag;
      r.victim_valid = 1'b1;
      r.victim_address = laddr_mem[s][w];
      r.victim_clean = clean_mem[s][w];
      r.fill_request = (cmd != CMD_WRITEBACK);
      touch_way(s, w, n);
      laddr_mem[s][w] = addr;
      if (cmd == CMD_STORE) clean_mem[s][w] = 1'b0;
      else if (cmd == CMD_LOAD) clean_mem[s][w] = 1'b1;
      else clean_mem[s][w] = lclean;
      miss_cnt = miss_cnt + 1'b1;
      found = 0;
    end
    r.hit = (r.victim_valid == 1'b0);
    r.way = w[3:0];
    r.hit_total = hit_cnt;
    r.miss_total = miss_cnt;
    return r;
  endfunction

  task automatic send_access(logic [1:0] cmd, logic [FIELD_AW-1:0] addr, logic lclean);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_line_clean <= lclean;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_access(cmd, addr, lclean));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LINE_SHIFT:  m_line_shift = val[4:0];
      CFG_SET_MASK:    m_set_mask = val;
      CFG_WAYS_IN_USE: m_ways = val[4:0];
      default:         m_policy = val[0];
    endcase
  endtask

  task automatic configure(int shift, int mask, int ways, logic pol);
    wait_drained();
    write_reg(CFG_LINE_SHIFT, 13'(shift));
    write_reg(CFG_SET_MASK, 13'(mask));
    write_reg(CFG_WAYS_IN_USE, 13'(ways));
    write_reg(CFG_POLICY_SELECT, 13'(pol));
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [FIELD_AW-1:0] wide_random();
    return FIELD_AW'({$urandom(), $urandom()});
  endfunction

  // addresses drawn from a small line pool so sets see hits and conflicts
  function automatic logic [FIELD_AW-1:0] pooled_addr();
    logic [FIELD_AW-1:0] line, offs;
    line = FIELD_AW'($urandom_range(0, 47));
    if ($urandom_range(0, 7) == 0) line = line | (FIELD_AW'(1) << $urandom_range(13, 16));
    offs = wide_random() & ((FIELD_AW'(1) << m_line_shift) - 1'b1);
    return (line << m_line_shift) | offs;
  endfunction

  task automatic send_random(int count);
    logic [FIELD_AW-1:0] a;
    for (int i = 0; i < count; i++) begin
      a = ($urandom_range(0, 3) == 0) ? wide_random() : pooled_addr();
      send_access(2'($urandom_range(0, 3)), a, 1'($urandom()));
    end
  endtask

  task automatic test_directed();
    send_access(CMD_LOAD, '0, 1'b0);
    send_access(CMD_STORE, 48'h3F, 1'b0);
    send_access(CMD_WRITEBACK, 48'h0, 1'b1);
    send_access(CMD_WRITEBACK, 48'h0, 1'b0);
    send_access(CMD_SPARE, 48'h40, 1'b1);
    send_access(CMD_LOAD, '1, 1'b0);
    send_access(CMD_STORE, '1, 1'b1);
    send_access(CMD_WRITEBACK, 48'hAAAA_AAAA_AAAA, 1'b1);
    send_access(CMD_WRITEBACK, 48'h5555_5555_5555, 1'b0);
    for (int i = 1; i <= 6; i++) send_access(CMD_LOAD, 48'(i) << 13, 1'b0);
    send_access(CMD_LOAD, 48'h2000, 1'b0);
    configure(6, 127, 4, POLICY_NMRU);
    for (int i = 1; i <= 5; i++) send_access(CMD_STORE, 48'(i) << 13, 1'b0);
    send_access(CMD_LOAD, 48'h1_0000, 1'b1);
  endtask

  task automatic test_config_extremes();
    configure(0, 0, 0, POLICY_LRU);
    send_random(30);
    configure(31, 8191, 31, POLICY_NMRU);
    send_random(30);
    configure(16, 8191, 16, POLICY_LRU);
    send_random(30);
    configure(0, 0, 1, POLICY_NMRU);
    send_random(20);
    configure(6, 127, 17, POLICY_LRU);
    send_random(30);
    configure(3, 3, 2, POLICY_LRU);
    send_random(30);
  endtask

  task automatic test_backpressure();
    configure(6, 7, 4, POLICY_LRU);
    hold_cycles = 300;
    max_gap = 0;
    send_random(40);
    max_gap = 3;
    wait_drained();
    send_random(20);
    max_gap = 0;
    send_random(40);
    max_gap = 3;
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 8; p++) begin
      configure($urandom_range(0, 16), (1 << $urandom_range(0, 13)) - 1,
                $urandom_range(1, 16), 1'($urandom()));
      send_random(65);
    end
  endtask

  // result checker and receiver stall generator
  always @(posedge clk) begin
    access_result_t e;
    int unsigned stall_left;
    if (!rst_n) begin
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          e = expected_q.pop_front();
          if (out_hit !== e.hit || out_way !== e.way || out_victim_valid !== e.victim_valid ||
              out_victim_address !== e.victim_address ||
              out_victim_clean !== e.victim_clean || out_fill_request !== e.fill_request ||
              out_hit_total !== e.hit_total || out_miss_total !== e.miss_total) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  exp hit=%0b way=%0d vv=%0b va=%h vc=%0b fill=%0b ht=%0d mt=%0d",
                       e.hit, e.way, e.victim_valid, e.victim_address, e.victim_clean,
                       e.fill_request, e.hit_total, e.miss_total);
              $display("  got hit=%0b way=%0d vv=%0b va=%h vc=%0b fill=%0b ht=%0d mt=%0d",
                       out_hit, out_way, out_victim_valid, out_victim_address,
                       out_victim_clean, out_fill_request, out_hit_total, out_miss_total);
            end
          end
        end
        stall_left = (max_gap == 0) ? 0 : $urandom_range(0, 3);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    max_gap = 3;
    hold_cycles = 0;
    for (int s = 0; s < N_SETS; s++)
      for (int w = 0; w < N_WAYS; w++) begin
        tag_mem[s][w] = '0;
        laddr_mem[s][w] = '0;
        rank_mem[s][w] = 4'(w);
        clean_mem[s][w] = 1'b0;
      end
    hit_cnt = '0;
    miss_cnt = '0;
    m_line_shift = 5'd6;
    m_set_mask = 13'd127;
    m_ways = 5'd4;
    m_policy = POLICY_LRU;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
